>>> sv/tolp_pkg.sv
`default_nettype none
package tolp_pkg;

  localparam logic [7:0] CodeIac   = 8'd255;
  localparam logic [7:0] CodeNop   = 8'd241;
  localparam logic [7:0] CodeDo    = 8'd253;
  localparam logic [7:0] CodeDont  = 8'd254;
  localparam logic [7:0] OptEcho   = 8'd1;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharLf    = 8'd10;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_in_packet;
  } tolp_in_t;

  typedef struct packed {
    logic       line_valid;
    logic [6:0] line_byte;
    logic       line_end;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       append_newline;
    logic       echo_enabled;
    logic       connection_open;
  } tolp_out_t;

  // handshake state between the input register and the result register
  typedef struct packed {
    logic fire;
  } tolp_flow_t;

endpackage
`default_nettype wire

>>> sv/tolp_in_stage.sv
`default_nettype none
module tolp_in_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  tolp_pkg::tolp_in_t  in_data_i,
  input  wire                 advance_i,
  output tolp_pkg::tolp_flow_t flow_o,
  output tolp_pkg::tolp_in_t  item_o
);

  logic               valid_q;
  logic               valid_d;
  tolp_pkg::tolp_in_t data_q;
  logic               accept;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign flow_o.fire = valid_q && advance_i;
  assign item_o      = data_q;

endmodule
`default_nettype wire

>>> sv/tolp_step.sv
`default_nettype none
module tolp_step (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tolp_pkg::tolp_flow_t flow_i,
  input  tolp_pkg::tolp_in_t   item_i,
  output tolp_pkg::tolp_out_t  res_o
);

  localparam logic [1:0] StIdle     = 2'd0;
  localparam logic [1:0] StAfterIac = 2'd1;
  localparam logic [1:0] StAfterCmd = 2'd2;

  logic [1:0] stage_q, stage_d;
  logic [7:0] cmd_q, cmd_d;
  logic       pm_q, pm_d;
  logic       cr_q, cr_d;
  logic       lf_q, lf_d;
  logic       echo_q, echo_d;
  logic       open_q, open_d;
  logic [7:0] b;
  tolp_pkg::tolp_out_t res;

  assign b = item_i.data_byte;

  always_comb begin
    stage_d = stage_q;
    cmd_d   = cmd_q;
    pm_d    = pm_q;
    cr_d    = cr_q;
    lf_d    = lf_q;
    echo_d  = echo_q;
    open_d  = open_q;
    res     = '0;
    if (item_i.req_type) begin
      // disconnect aborts the packet, turns echo off and closes the connection
      stage_d = StIdle;
      cmd_d   = '0;
      pm_d    = 1'b0;
      cr_d    = 1'b0;
      lf_d    = 1'b0;
      echo_d  = 1'b0;
      open_d  = 1'b0;
    end else begin
      if (!pm_q) begin
        unique case (stage_q)
          StIdle: begin
            if (b == tolp_pkg::CodeIac) begin
              stage_d = StAfterIac;
              open_d  = 1'b1;
            end else if (!b[7]) begin
              pm_d = 1'b1;
            end
          end
          StAfterIac: begin
            cmd_d   = b;
            stage_d = (b == tolp_pkg::CodeNop) ? StIdle : StAfterCmd;
          end
          default: begin
            // option byte, stage value three handled the same way
            stage_d = StIdle;
            if (b == tolp_pkg::OptEcho) begin
              if (cmd_q == tolp_pkg::CodeDo) begin
                echo_d = 1'b1;
              end else if (cmd_q == tolp_pkg::CodeDont) begin
                echo_d = 1'b0;
              end
            end
          end
        endcase
      end
      if (pm_d) begin
        if (b == tolp_pkg::CharLf) begin
          lf_d = 1'b1;
        end else if (!b[7] && (b != 8'd0)) begin
          res.line_valid = 1'b1;
          res.line_byte  = b[6:0];
          if (b == tolp_pkg::CharCr) begin
            res.line_end = 1'b1;
            cr_d         = 1'b1;
          end
        end
        if (echo_d) begin
          res.echo_valid = 1'b1;
          res.echo_byte  = b;
        end
        res.append_newline = item_i.last_in_packet && echo_d && cr_d && !lf_d;
      end
      if (item_i.last_in_packet) begin
        stage_d = StIdle;
        cmd_d   = '0;
        pm_d    = 1'b0;
        cr_d    = 1'b0;
        lf_d    = 1'b0;
      end
    end
    res.echo_enabled    = echo_d;
    res.connection_open = open_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StIdle;
      cmd_q   <= '0;
      pm_q    <= 1'b0;
      cr_q    <= 1'b0;
      lf_q    <= 1'b0;
      echo_q  <= 1'b0;
      open_q  <= 1'b0;
    end else if (flow_i.fire) begin
      stage_q <= stage_d;
      cmd_q   <= cmd_d;
      pm_q    <= pm_d;
      cr_q    <= cr_d;
      lf_q    <= lf_d;
      echo_q  <= echo_d;
      open_q  <= open_d;
    end
  end

  assign res_o = res;

endmodule
`default_nettype wire

>>> sv/tolp_out_stage.sv
`default_nettype none
module tolp_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tolp_pkg::tolp_flow_t flow_i,
  input  tolp_pkg::tolp_out_t  res_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output tolp_pkg::tolp_out_t  out_data_o
);

  logic                valid_q;
  logic                valid_d;
  tolp_pkg::tolp_out_t data_q;

  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (flow_i.fire) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.fire) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

>>> sv/telnet_option_and_line_parser_core.sv
// channel | direction | handshake              | payload
// input   | in        | in_valid_i / in_ready_o   | in_data_i  (tolp_in_t)
// result  | out       | out_valid_o / out_ready_i | out_data_o (tolp_out_t)
//
// one item per cycle sustained while the result side is not stalled; a result is valid once its item has passed
// (input register, then parser state update into the result register)
// the parser state is a handful of flags updated once per item, so the
// state loop sets the rate
// reset clears both valid flags and all parser state, no clearing pass
// a stalled result holds in its register; in_ready_o drops only when both
// registers are full and the result side is stalled
`default_nettype none
module telnet_option_and_line_parser_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  tolp_pkg::tolp_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tolp_pkg::tolp_out_t out_data_o
);

  tolp_pkg::tolp_flow_t flow;
  tolp_pkg::tolp_in_t   item;
  tolp_pkg::tolp_out_t  res;
  logic                 advance;

  tolp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .flow_o     (flow),
    .item_o     (item)
  );

  tolp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flow_i (flow),
    .item_i (item),
    .res_o  (res)
  );

  tolp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flow_i      (flow),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> sv/tolp_checker.sv
`default_nettype none
module tolp_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input tolp_pkg::tolp_out_t out_data_o
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // nothing stored means zero byte and no line end
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.line_valid |->
      out_data_o.line_byte == 7'd0 && !out_data_o.line_end)
    else $error("line fields set without a stored byte");

  // a line end is always a stored carriage return
  a_line_end_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_end |->
      out_data_o.line_valid && out_data_o.line_byte == 7'd13)
    else $error("line end on a byte other than carriage return");

  // echo and appended line feed need echo mode
  a_echo_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.echo_valid || out_data_o.append_newline) |->
      out_data_o.echo_enabled)
    else $error("echo output while echo mode is off");

  // no echo means zero echo byte
  a_echo_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.echo_valid |-> out_data_o.echo_byte == 8'd0)
    else $error("echo byte set without echo");

endmodule

bind telnet_option_and_line_parser_core tolp_checker u_tolp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;

  localparam logic [7:0] CodeWill = 8'd251;
  localparam logic [7:0] CodeWont = 8'd252;
  localparam logic [7:0] HighByte = 8'd128;
  localparam int ItemTarget = 420;

  typedef enum logic [1:0] {
    StageIdle,
    StageIac,
    StageCommand
  } parse_stage_e;

  typedef logic [7:0] byte_q_t[$];

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  tolp_pkg::tolp_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  tolp_pkg::tolp_out_t out_data_o;

  telnet_option_and_line_parser_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // parser state as the block should hold it
  parse_stage_e stage;
  logic [7:0]   cmd_byte;
  logic         in_payload;
  logic         cr_seen;
  logic         lf_seen;
  logic         echo_on;
  logic         conn_open;

  tolp_pkg::tolp_out_t parse_results_q[$];

  int  items_sent;
  int  packets_done;
  int  disconnects_sent;
  int  results_checked;
  int  mismatch_count;
  int  hold_left;
  int  stall_left;
  bit  quiet;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic tolp_pkg::tolp_in_t mk_item(logic req, logic [7:0] b, logic last);
    tolp_pkg::tolp_in_t it;
    it.req_type       = req;
    it.data_byte      = b;
    it.last_in_packet = last;
    return it;
  endfunction

  task automatic restart_packet();
    stage      = StageIdle;
    cmd_byte   = 8'd0;
    in_payload = 1'b0;
    cr_seen    = 1'b0;
    lf_seen    = 1'b0;
  endtask

  task automatic parse_telnet_byte(input tolp_pkg::tolp_in_t item,
                                   output tolp_pkg::tolp_out_t res);
    logic [7:0] b;
    b   = item.data_byte;
    res = '0;
    if (item.req_type) begin
      restart_packet();
      echo_on   = 1'b0;
      conn_open = 1'b0;
    end else begin
      if (!in_payload) begin
        case (stage)
          StageIdle: begin
            if (b == tolp_pkg::CodeIac) begin
              stage     = StageIac;
              conn_open = 1'b1;
            end else if (b < HighByte) begin
              in_payload = 1'b1;
            end
          end
          StageIac: begin
            cmd_byte = b;
            stage    = (b == tolp_pkg::CodeNop) ? StageIdle : StageCommand;
          end
          // option byte; an impossible stage value is handled the same way
          default: begin
            stage = StageIdle;
            if (b == tolp_pkg::OptEcho) begin
              if (cmd_byte == tolp_pkg::CodeDo) echo_on = 1'b1;
              else if (cmd_byte == tolp_pkg::CodeDont) echo_on = 1'b0;
            end
          end
        endcase
      end
      if (in_payload) begin
        if (b == tolp_pkg::CharLf) begin
          lf_seen = 1'b1;
        end else if (b < HighByte && b != 8'd0) begin
          res.line_valid = 1'b1;
          res.line_byte  = b[6:0];
          if (b == tolp_pkg::CharCr) begin
            res.line_end = 1'b1;
            cr_seen      = 1'b1;
          end
        end
        if (echo_on) begin
          res.echo_valid = 1'b1;
          res.echo_byte  = b;
        end
        if (item.last_in_packet && echo_on && cr_seen && !lf_seen) res.append_newline = 1'b1;
      end
      if (item.last_in_packet) restart_packet();
    end
    res.echo_enabled    = echo_on;
    res.connection_open = conn_open;
  endtask

  task automatic send_item(input tolp_pkg::tolp_in_t item);
    int                  gap;
    tolp_pkg::tolp_out_t res;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    parse_telnet_byte(item, res);
    parse_results_q.push_back(res);
    items_sent++;
    if (item.req_type) disconnects_sent++;
    else if (item.last_in_packet) packets_done++;
  endtask

  task automatic send_packet(input byte_q_t bytes);
    foreach (bytes[i]) send_item(mk_item(1'b0, bytes[i], i == bytes.size() - 1));
  endtask

  // sender stops and waits for the block to empty
  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    tolp_pkg::tolp_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parse_results_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = parse_results_q.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: result mismatch, expected %h got %h", $time, want, out_data_o);
          mismatch_count++;
        end
        results_checked++;
      end
    end
  end

  // result side: long hold-off first, then random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet) stall_left = pick_gap();
    end
  end

  task automatic test_option_sequences();
    // lone IAC, then NOP, a skipped high byte and DO ECHO, all without payload
    send_packet({tolp_pkg::CodeIac});
    send_packet({tolp_pkg::CodeIac, tolp_pkg::CodeNop, 8'd200, tolp_pkg::CodeIac,
                 tolp_pkg::CodeDo, tolp_pkg::OptEcho});
  endtask

  task automatic test_line_payload();
    // CR with no LF asks for a newline; zero byte is echoed only
    send_packet({8'd127, 8'd0, tolp_pkg::CharCr});
    // WILL ECHO has no effect; CR then LF, high byte in payload
    send_packet({tolp_pkg::CodeIac, CodeWill, tolp_pkg::OptEcho, 8'("h"), tolp_pkg::CharCr,
                 tolp_pkg::CharLf, 8'd255});
    // echo off, high byte skipped before the payload starts
    send_packet({tolp_pkg::CodeIac, tolp_pkg::CodeDont, tolp_pkg::OptEcho, HighByte, 8'("q")});
  endtask

  task automatic test_disconnect();
    send_item(mk_item(1'b0, tolp_pkg::CodeIac, 1'b0));
    send_item(mk_item(1'b1, 8'hff, 1'b1));
    send_item(mk_item(1'b1, 8'h00, 1'b0));
  endtask

  task automatic test_backpressure();
    byte_q_t pkt;
    pkt = {tolp_pkg::CodeIac, tolp_pkg::CodeDo, tolp_pkg::OptEcho};
    repeat (17) pkt.push_back(8'($urandom_range(0, 255)));
    quiet     = 1'b1;
    hold_left = 80;
    send_packet(pkt);
    quiet = 1'b0;
    wait_all_results();
  endtask

  task automatic test_random_sessions();
    byte_q_t    pkt;
    int         kind;
    int         r;
    logic [7:0] cmd;
    while (items_sent < ItemTarget) begin
      quiet = ($urandom_range(0, 9) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 8) begin
        send_item(mk_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end else if (kind < 16) begin
        repeat ($urandom_range(1, 6))
          send_item(mk_item(1'b0, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0));
      end else if (kind < 22) begin
        // sequence cut short by the packet end or by a disconnect
        send_item(mk_item(1'b0, tolp_pkg::CodeIac, 1'b0));
        if ($urandom_range(0, 1)) send_item(mk_item(1'b0, tolp_pkg::CodeDo, 1'b0));
        send_item(mk_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1));
      end else begin
        pkt = {};
        repeat ($urandom_range(0, 3)) begin
          r   = $urandom_range(0, 99);
          cmd = (r < 35) ? tolp_pkg::CodeDo : (r < 65) ? tolp_pkg::CodeDont :
                (r < 70) ? CodeWill : (r < 75) ? CodeWont :
                (r < 85) ? tolp_pkg::CodeNop : 8'($urandom_range(128, 255));
          pkt.push_back(tolp_pkg::CodeIac);
          pkt.push_back(cmd);
          if (cmd != tolp_pkg::CodeNop)
            pkt.push_back(($urandom_range(0, 9) < 7) ? tolp_pkg::OptEcho :
                          8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0) pkt.push_back(8'($urandom_range(128, 254)));
        repeat ($urandom_range(0, 10)) begin
          r = $urandom_range(0, 99);
          pkt.push_back((r < 50) ? 8'($urandom_range(32, 126)) : (r < 65) ? tolp_pkg::CharCr :
                        (r < 75) ? tolp_pkg::CharLf : (r < 80) ? 8'd0 :
                        8'($urandom_range(0, 255)));
        end
        if (pkt.size() == 0) pkt.push_back(8'("x"));
        send_packet(pkt);
      end
      if ($urandom_range(0, 29) == 0) wait_all_results();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    hold_left   = 0;
    stall_left  = 0;
    quiet       = 1'b0;
    restart_packet();
    echo_on   = 1'b0;
    conn_open = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_option_sequences();
    test_line_payload();
    test_disconnect();
    wait_all_results();
    test_backpressure();
    test_random_sessions();

    wait_all_results();
    repeat (10) @(posedge clk_i);
    $display("covered %0d items: %0d packets, %0d disconnects, one long result stall",
             items_sent, packets_done, disconnects_sent);
    $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && parse_results_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", parse_results_q.size());
    $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire
